### rtl/core/rotation_matrix_to_quaternion_defines.svh
// assertion macros for the rotation matrix to quaternion core
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RMQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RMQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rmq_pkg.sv
`timescale 1ns / 1ps
package rmq_pkg;
    // port width of matrix elements and quaternion components
    localparam int DATA_W        = 16;
    // default fraction bits
    localparam int FRAC_BITS_DEF = 14;
    // width of sums and differences of two elements
    localparam int ELEM_W        = 18;
    // quaternion lane codes
    localparam logic [1:0] LANE_X = 2'd0;
    localparam logic [1:0] LANE_Y = 2'd1;
    localparam logic [1:0] LANE_Z = 2'd2;
    localparam logic [1:0] LANE_W = 2'd3;
endpackage

### rtl/core/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// channel | valid   | stall   | payload
// request | i_valid | o_stall | i_m00 .. i_m22
// result  | o_valid | i_stall | o_qx o_qy o_qz o_qw o_degenerate
//
// one request enters every cycle while o_stall is low; the pipeline holds
// SW = ceil((max(FRAC_BITS,17) + 1 + FRAC_BITS) / 2) square-root stages
// (one root bit per stage) and FRAC_BITS + 1 divider stages (one quotient bit each).
// reset clears the valid bits only; no state carries between requests.
// a stalled result parks in a skid register; the pipeline freezes only while it is full.
`include "rotation_matrix_to_quaternion_defines.svh"
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_m00,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_m01,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_m02,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_m10,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_m11,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_m12,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_m20,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_m21,
    input  logic signed [rmq_pkg::DATA_W-1:0]    i_m22,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [rmq_pkg::DATA_W-1:0]    o_qx,
    output logic signed [rmq_pkg::DATA_W-1:0]    o_qy,
    output logic signed [rmq_pkg::DATA_W-1:0]    o_qz,
    output logic signed [rmq_pkg::DATA_W-1:0]    o_qw,
    output logic                                 o_degenerate
);
    import rmq_pkg::*;

    localparam int MXF  = (FRAC_BITS > 17) ? FRAC_BITS : 17;
    localparam int AW   = MXF + 2;                 // signed root argument
    localparam int NW   = AW - 1 + FRAC_BITS;      // argument scaled by one
    localparam int SW   = (NW + 1) / 2;            // root width
    localparam int QW   = FRAC_BITS + 1;           // quotient bits
    localparam int CW0  = FRAC_BITS + 18;
    localparam int CW1  = SW + 1 + QW;
    localparam int CW   = (CW0 > CW1) ? CW0 : CW1; // divider compare width
    localparam int MW0  = (QW > SW) ? QW : SW;
    localparam int MW   = (MW0 > 17) ? MW0 : 17;   // magnitude width at output
    localparam int DW   = 4 * ELEM_W;
    localparam int L    = SW + QW + 4;             // pipeline stages
    localparam longint ONE_L  = 64'sd1 <<< FRAC_BITS;
    localparam longint HI_P_L = (ONE_L < 32767) ? ONE_L : 32767;
    localparam longint HI_N_L = (ONE_L < 32768) ? ONE_L : 32768;
    localparam logic [MW-1:0] HI_POS = MW'(HI_P_L);
    localparam logic [MW-1:0] HI_NEG = MW'(HI_N_L);

    logic [L-1:0] r_v;
    logic         en;
    logic         r_sk_v;

    assign en      = !r_sk_v;
    assign o_stall = r_sk_v;

    // valid bits advance with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[L-2:0], i_valid};
        end
    end

    // stage 0: input register
    logic signed [DATA_W-1:0] r_m [9];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m[0] <= i_m00; r_m[1] <= i_m01; r_m[2] <= i_m02;
            r_m[3] <= i_m10; r_m[4] <= i_m11; r_m[5] <= i_m12;
            r_m[6] <= i_m20; r_m[7] <= i_m21; r_m[8] <= i_m22;
        end
    end

    // stage 1: trace, pivot choice, root argument and lane numerators
    logic signed [AW-1:0]     a00, a11, a22, trace, arg;
    logic signed [ELEM_W-1:0] e [9];
    logic signed [ELEM_W-1:0] n_d [4];
    logic [1:0]               n_main;
    logic                     n_dg;
    logic [NW-1:0]            n_n;

    always_comb begin
        for (int q = 0; q < 9; q++) begin
            e[q] = ELEM_W'(r_m[q]);
        end
        a00   = AW'(r_m[0]);
        a11   = AW'(r_m[4]);
        a22   = AW'(r_m[8]);
        trace = a00 + a11 + a22;
        n_dg  = 1'b0;
        if (trace > 0) begin
            n_main = LANE_W;
            arg    = trace + AW'(ONE_L);
            n_d[0] = e[7] - e[5];
            n_d[1] = e[2] - e[6];
            n_d[2] = e[3] - e[1];
            n_d[3] = '0;
        end else if (a11 > a00 && a22 <= a11) begin
            n_main = LANE_Y;
            arg    = a11 - a22 - a00 + AW'(ONE_L);
            n_d[3] = e[2] - e[6];
            n_d[2] = e[7] + e[5];
            n_d[0] = e[1] + e[3];
            n_d[1] = '0;
        end else if (a22 > a00 && a22 > a11) begin
            n_main = LANE_Z;
            arg    = a22 - a00 - a11 + AW'(ONE_L);
            n_d[3] = e[3] - e[1];
            n_d[0] = e[2] + e[6];
            n_d[1] = e[5] + e[7];
            n_d[2] = '0;
        end else begin
            n_main = LANE_X;
            arg    = a00 - a11 - a22 + AW'(ONE_L);
            n_d[3] = e[7] - e[5];
            n_d[1] = e[3] + e[1];
            n_d[2] = e[6] + e[2];
            n_d[0] = '0;
        end
        if (arg <= 0) begin
            n_dg = 1'b1;
            n_n  = '0;
        end else begin
            n_n = NW'(arg[AW-2:0]) << FRAC_BITS;
        end
    end

    // square-root stages, index 0 is the stage-1 register
    logic [NW-1:0] r_rem [SW+1];
    logic [NW-1:0] r_res [SW+1];
    logic [DW-1:0] r_sd  [SW+1];
    logic [1:0]    r_smn [SW+1];
    logic          r_sdg [SW+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem[0] <= n_n;
            r_res[0] <= '0;
            r_sd[0]  <= {n_d[3], n_d[2], n_d[1], n_d[0]};
            r_smn[0] <= n_main;
            r_sdg[0] <= n_dg;
        end
    end

    for (genvar t = 1; t <= SW; t++) begin : g_sqrt
        localparam int BP = 2 * (SW - t);
        logic [NW-1:0] trial;
        logic          ge;
        assign trial = r_res[t-1] + (NW'(1) << BP);
        assign ge    = r_rem[t-1] >= trial;
        // one root bit per stage
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[t] <= ge ? r_rem[t-1] - trial : r_rem[t-1];
                r_res[t] <= ge ? (r_res[t-1] >> 1) + (NW'(1) << BP) : r_res[t-1] >> 1;
                r_sd[t]  <= r_sd[t-1];
                r_smn[t] <= r_smn[t-1];
                r_sdg[t] <= r_sdg[t-1];
            end
        end
    end

    // divider setup: rounded numerators, saturation precheck
    logic [SW-1:0]  s_root;
    logic [SW:0]    s_den;
    logic [CW-1:0]  n_num [4];
    logic [3:0]     n_neg, n_sat;

    always_comb begin
        logic signed [ELEM_W-1:0] dl;
        logic [ELEM_W-1:0]        mag;
        s_root = r_res[SW][SW-1:0];
        s_den  = {s_root, 1'b0};
        for (int l = 0; l < 4; l++) begin
            dl       = r_sd[SW][l*ELEM_W +: ELEM_W];
            n_neg[l] = dl < 0;
            mag      = n_neg[l] ? ELEM_W'(-dl) : ELEM_W'(dl);
            n_num[l] = (CW'(mag) << FRAC_BITS) + CW'(s_root);
            n_sat[l] = n_num[l] >= (CW'(s_den) << QW);
        end
    end

    logic [CW-1:0] r_dr  [QW+1][4];
    logic [QW-1:0] r_dq  [QW+1][4];
    logic [3:0]    r_neg [QW+1];
    logic [3:0]    r_sat [QW+1];
    logic [SW:0]   r_den [QW+1];
    logic [SW-1:0] r_mv  [QW+1];
    logic [1:0]    r_dmn [QW+1];
    logic          r_ddg [QW+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 4; l++) begin
                r_dr[0][l] <= n_num[l];
                r_dq[0][l] <= '0;
            end
            r_neg[0] <= n_neg;
            r_sat[0] <= n_sat;
            r_den[0] <= s_den;
            r_mv[0]  <= SW'((SW+1)'(s_root) + (SW+1)'(1) >> 1);
            r_dmn[0] <= r_smn[SW];
            r_ddg[0] <= r_sdg[SW];
        end
    end

    for (genvar u = 1; u <= QW; u++) begin : g_div
        localparam int BQ = QW - u;
        logic [CW-1:0] dtr;
        assign dtr = CW'(r_den[u-1]) << BQ;
        // one quotient bit per stage on all four lanes
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int l = 0; l < 4; l++) begin
                    if (r_dr[u-1][l] >= dtr) begin
                        r_dr[u][l] <= r_dr[u-1][l] - dtr;
                        r_dq[u][l] <= r_dq[u-1][l] | (QW'(1) << BQ);
                    end else begin
                        r_dr[u][l] <= r_dr[u-1][l];
                        r_dq[u][l] <= r_dq[u-1][l];
                    end
                end
                r_neg[u] <= r_neg[u-1];
                r_sat[u] <= r_sat[u-1];
                r_den[u] <= r_den[u-1];
                r_mv[u]  <= r_mv[u-1];
                r_dmn[u] <= r_dmn[u-1];
                r_ddg[u] <= r_ddg[u-1];
            end
        end
    end

    // output stage: pick main lane, clip, apply sign, zero degenerate results
    logic [DATA_W-1:0] n_q [4];
    always_comb begin
        logic [MW-1:0] mg, lim;
        logic          ng;
        for (int l = 0; l < 4; l++) begin
            ng = 1'b0;
            if (2'(l) == r_dmn[QW]) begin
                mg = MW'(r_mv[QW]);
            end else if (r_sat[QW][l]) begin
                mg = HI_NEG;
                ng = r_neg[QW][l];
            end else begin
                mg = MW'(r_dq[QW][l]);
                ng = r_neg[QW][l];
            end
            lim = ng ? HI_NEG : HI_POS;
            if (mg > lim) begin
                mg = lim;
            end
            if (r_ddg[QW]) begin
                n_q[l] = '0;
            end else begin
                n_q[l] = ng ? DATA_W'(-mg) : DATA_W'(mg);
            end
        end
    end

    logic [DATA_W-1:0] r_q  [4];
    logic              r_dg;
    logic [DATA_W-1:0] r_kq [4];
    logic              r_kdg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q  <= n_q;
            r_dg <= r_ddg[QW];
        end
    end

    // skid register catches a stalled result so the pipeline keeps going until the skid is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (!i_stall) begin
                r_sk_v <= 1'b0;
            end
        end else if (r_v[L-1] && i_stall) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_v) begin
            r_kq  <= r_q;
            r_kdg <= r_dg;
        end
    end

    assign o_valid      = r_sk_v || r_v[L-1];
    assign o_qx         = r_sk_v ? r_kq[LANE_X] : r_q[LANE_X];
    assign o_qy         = r_sk_v ? r_kq[LANE_Y] : r_q[LANE_Y];
    assign o_qz         = r_sk_v ? r_kq[LANE_Z] : r_q[LANE_Z];
    assign o_qw         = r_sk_v ? r_kq[LANE_W] : r_q[LANE_W];
    assign o_degenerate = r_sk_v ? r_kdg : r_dg;

    `RMQ_ASSERT_NOW(a_degen_zero, o_valid && o_degenerate, o_qx == 0 && o_qy == 0 && o_qz == 0 && o_qw == 0, "degenerate result with nonzero component")
    `RMQ_ASSERT_NEXT(a_skid_holds, r_sk_v && i_stall, r_sk_v && o_valid, "parked result lost under stall")
    `RMQ_ASSERT_NOW(a_skid_valid, !o_valid, !r_sk_v, "skid full without a shown result")
endmodule

### bench/rotation_matrix_to_quaternion_test.sv
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_test;
    import rmq_pkg::*;

    localparam int FB      = FRAC_BITS_DEF;
    localparam int LATENCY = ((((FB > 17) ? FB : 17) + 1 + FB + 1) / 2) + FB + 5;
    localparam int WATCHDOG_LIMIT = 20 * LATENCY + 200;
    localparam int N_RANDOM = 1250;

    typedef logic signed [DATA_W-1:0] elem_t;

    typedef struct packed {
        elem_t qx;
        elem_t qy;
        elem_t qz;
        elem_t qw;
        logic  degenerate;
    } quat_t;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    logic  out_valid;
    logic  out_stall;
    elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
    elem_t qx, qy, qz, qw;
    logic  degenerate;
    bit    quiet_phase;
    int    idle_cycles;

    rotation_matrix_to_quaternion dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(out_stall),
        .i_m00(m00), .i_m01(m01), .i_m02(m02),
        .i_m10(m10), .i_m11(m11), .i_m12(m12),
        .i_m20(m20), .i_m21(m21), .i_m22(m22),
        .o_valid(out_valid), .i_stall(in_stall),
        .o_qx(qx), .o_qy(qy), .o_qz(qz), .o_qw(qw),
        .o_degenerate(degenerate)
    );

    // expected quaternion queue and comparison
    class quat_scoreboard;
        quat_t pending[$];
        int    mismatches;

        static function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        static function longint clamp_unit(longint v);
            longint hi;
            longint lo;
            hi = ((64'sd1 << FB) < 32767) ? (64'sd1 << FB) : 32767;
            lo = (-(64'sd1 << FB) > -32768) ? -(64'sd1 << FB) : -32768;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // d * one / (2s), rounded half away from zero
        static function longint scaled_quot(longint d, longint unsigned s);
            longint unsigned mag;
            longint unsigned q;
            mag = (d < 0) ? longint'(-d) : longint'(d);
            q   = ((mag << FB) + s) / (2 * s);
            return clamp_unit((d < 0) ? -longint'(q) : longint'(q));
        endfunction

        static function quat_t to_quaternion(elem_t e[9]);
            longint m[3][3];
            longint q[4];
            longint trace;
            longint arg;
            longint unsigned s;
            int i, j, k;
            quat_t r;
            for (int a = 0; a < 9; a++) m[a / 3][a % 3] = e[a];
            q = '{0, 0, 0, 0};
            r.degenerate = 1'b0;
            trace = m[0][0] + m[1][1] + m[2][2];
            if (trace > 0) begin
                arg  = trace + (64'sd1 << FB);
                s    = int_sqrt(longint'(arg) << FB);
                q[3] = clamp_unit(longint'((s + 1) >> 1));
                q[0] = scaled_quot(m[2][1] - m[1][2], s);
                q[1] = scaled_quot(m[0][2] - m[2][0], s);
                q[2] = scaled_quot(m[1][0] - m[0][1], s);
            end else begin
                i = 0;
                if (m[1][1] > m[0][0]) i = 1;
                if (m[2][2] > m[i][i]) i = 2;
                j = (i + 1) % 3;
                k = (j + 1) % 3;
                arg = m[i][i] - m[j][j] - m[k][k] + (64'sd1 << FB);
                if (arg <= 0) begin
                    r.degenerate = 1'b1;
                end else begin
                    s    = int_sqrt(longint'(arg) << FB);
                    q[i] = clamp_unit(longint'((s + 1) >> 1));
                    q[3] = scaled_quot(m[k][j] - m[j][k], s);
                    q[j] = scaled_quot(m[j][i] + m[i][j], s);
                    q[k] = scaled_quot(m[k][i] + m[i][k], s);
                end
            end
            r.qx = q[0][15:0];
            r.qy = q[1][15:0];
            r.qz = q[2][15:0];
            r.qw = q[3][15:0];
            return r;
        endfunction

        function void note_request(elem_t e[9]);
            pending.push_back(to_quaternion(e));
        endfunction

        function void check_result(quat_t got);
            quat_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h %h %h %h deg=%b",
                             got.qx, got.qy, got.qz, got.qw, got.degenerate);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d %0d %0d %0d deg=%b, got %0d %0d %0d %0d deg=%b",
                             want.qx, want.qy, want.qz, want.qw, want.degenerate,
                             got.qx, got.qy, got.qz, got.qw, got.degenerate);
            end
        endfunction
    endclass

    quat_scoreboard board = new();

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stall bursts, sample accepted results
    initial begin
        int burst;
        in_stall = 1'b0;
        burst = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !in_stall)
                board.check_result('{qx, qy, qz, qw, degenerate});
            if (burst > 0) begin
                burst--;
            end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 12);
            end
            in_stall <= (burst > 0);
        end
    end

    // watchdog on cycles without any accepted request or result
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && !out_stall) || (out_valid && !in_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // present one request and hold it until accepted
    task automatic send_matrix(elem_t e[9]);
        in_valid <= 1'b1;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
            {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        do @(posedge clk); while (out_stall);
        board.note_request(e);
    endtask

    // random gap between requests
    task automatic maybe_idle();
        int gap;
        if (quiet_phase || $urandom_range(0, 7) != 0) return;
        gap = $urandom_range(1, 12);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    function automatic elem_t rand_unit();
        return elem_t'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // random matrix: mostly a large chosen diagonal over small noise, else uniform values
    function automatic void rand_matrix(ref elem_t e[9]);
        int mode;
        mode = $urandom_range(0, 9);
        for (int a = 0; a < 9; a++) begin
            if (mode == 0)      e[a] = elem_t'($urandom());
            else if (mode < 4)  e[a] = rand_unit();
            else                e[a] = elem_t'($signed($urandom_range(0, 8192)) - 4096);
        end
        if (mode >= 4) begin
            int d;
            d = $urandom_range(0, 3);
            for (int a = 0; a < 3; a++)
                e[a * 4] = (d == 3) ? elem_t'($urandom_range(8000, 16384))
                         : (a == d) ? elem_t'($urandom_range(4000, 16384))
                         : elem_t'(-$signed($urandom_range(4000, 16384)));
        end
    endfunction

    initial begin
        elem_t e[9];
        elem_t edge_vals[4];
        quiet_phase = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity and half-turns about each axis
        e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};     send_matrix(e);
        e = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};   send_matrix(e);
        e = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};   send_matrix(e);
        e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};   send_matrix(e);
        // quarter-turn about z
        e = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384};    send_matrix(e);
        // all-zero and ties on the diagonal
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                 send_matrix(e);
        e = '{-8192, 100, 0, 0, -8192, 0, 0, 0, -8192};   send_matrix(e);
        // negative diagonals: all-negative diagonal, and positive trace with one negative corner
        e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384};  send_matrix(e);
        e = '{-100, 0, 0, 0, 16384, 0, 0, 0, 16384};      send_matrix(e);
        // out-of-range extremes and tiny root with large quotient
        edge_vals = '{16'sh7fff, -16'sh8000, 16'sh0001, -16'sh0001};
        foreach (edge_vals[v]) begin
            foreach (e[a]) e[a] = edge_vals[(v + a) % 4];
            send_matrix(e);
        end
        e = '{-16384, 32767, -32768, -32768, -16383, 32767, 32767, -32768, 16384};
        send_matrix(e);
        e = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        send_matrix(e);
        e = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
        send_matrix(e);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 150) quiet_phase = 1'b1;
            maybe_idle();
            rand_matrix(e);
            send_matrix(e);
        end
        in_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (board.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
